### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the grid point search block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define NGPS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define NGPS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ngps_pkg.sv
// ----------------------------------------------------------------------------
// Grid point search package
// Sizes, register and command codes, and the microcode table of the search.
// ----------------------------------------------------------------------------
package ngps_pkg;

  localparam int MAX_ROWS   = 16;
  localparam int MAX_COLS   = 16;
  localparam int COORD_BITS = 12;

  localparam int GRID_W     = 4;
  localparam int PT_W       = 12;
  localparam int CFG_CNT_W  = 5;
  localparam int CFG_DIST_W = 26;

  localparam int ROW_IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ADDR_W    = 1 + ROW_IDX_W + COL_IDX_W;
  localparam int GRID_DEPTH = 2 * (2 ** ROW_IDX_W) * (2 ** COL_IDX_W);
  localparam int ENTRY_W   = 2 * COORD_BITS;
  localparam int SQ_W      = 2 * COORD_BITS;
  localparam int SUM_W     = SQ_W + 1;
  localparam int DIST_W    = (SUM_W > CFG_DIST_W) ? SUM_W : CFG_DIST_W;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef logic [ROW_IDX_W-1:0]  row_idx_t;
  typedef logic [COL_IDX_W-1:0]  col_idx_t;
  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [GRID_W-1:0]     grid_t;
  typedef logic [DIST_W-1:0]     dist_t;

  localparam logic [CFG_CNT_W-1:0]  ROWS_RESET  = 5'd16;
  localparam logic [CFG_CNT_W-1:0]  COLS_RESET  = 5'd16;
  localparam logic [CFG_DIST_W-1:0] START_RESET = 26'd10000;

  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_COLS  = 2'd1;
  localparam logic [1:0] REG_START = 2'd2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_WAIT   = 3'd0;
  localparam step_t STEP_INIT   = 3'd1;
  localparam step_t STEP_SCAN   = 3'd2;
  localparam step_t STEP_DRAIN0 = 3'd3;
  localparam step_t STEP_DRAIN1 = 3'd4;
  localparam step_t STEP_DRAIN2 = 3'd5;
  localparam step_t STEP_DONE   = 3'd6;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_QUERY,
    COND_EMPTY,
    COND_MORE,
    COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    logic in_ready;
    logic init;
    logic issue;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic query_acc;
    logic empty;
    logic more;
    logic out_free;
  } status_t;

  typedef struct packed {
    ctrl_t act;
    cond_e cond;
    logic  hold;
    step_t target;
  } uword_t;

  function automatic uword_t ucode_rom(input step_t step);
    uword_t w;
    w.act    = '0;
    w.cond   = COND_NEVER;
    w.hold   = 1'b0;
    w.target = STEP_WAIT;
    case (step)
      STEP_WAIT: begin
        w.act.in_ready = 1'b1;
        w.cond         = COND_QUERY;
        w.hold         = 1'b1;
        w.target       = STEP_INIT;
      end
      STEP_INIT: begin
        w.act.init = 1'b1;
        w.cond     = COND_EMPTY;
        w.target   = STEP_DONE;
      end
      STEP_SCAN: begin
        w.act.issue = 1'b1;
        w.cond      = COND_MORE;
        w.target    = STEP_SCAN;
      end
      STEP_DRAIN0, STEP_DRAIN1, STEP_DRAIN2: begin
        w.cond = COND_NEVER;
      end
      STEP_DONE: begin
        w.act.emit = 1'b1;
        w.cond     = COND_OUT_FREE;
        w.hold     = 1'b1;
        w.target   = STEP_WAIT;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/ngps_in_if.sv
// ----------------------------------------------------------------------------
// Grid point search input channel
// Load and query items with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface ngps_in_if;
  import ngps_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic              camera_side;
  logic [GRID_W-1:0] row;
  logic [GRID_W-1:0] col;
  logic [PT_W-1:0]   point_x;
  logic [PT_W-1:0]   point_y;

  modport source (
    output valid, cmd, camera_side, row, col, point_x, point_y,
    input  ready
  );

  modport sink (
    input  valid, cmd, camera_side, row, col, point_x, point_y,
    output ready
  );
endinterface

### hw/rtl/ngps_out_if.sv
// ----------------------------------------------------------------------------
// Grid point search result channel
// Row and column of the nearest point with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface ngps_out_if;
  import ngps_pkg::*;

  logic              valid;
  logic              ready;
  logic [GRID_W-1:0] best_row;
  logic [GRID_W-1:0] best_col;

  modport source (
    output valid, best_row, best_col,
    input  ready
  );

  modport sink (
    input  valid, best_row, best_col,
    output ready
  );
endinterface

### hw/rtl/nearest_grid_point_search.sv
// ----------------------------------------------------------------------------
// Nearest grid point search
// Two stored grids of points; a query returns the row and column of the stored
// point of least squared distance to the query, if below the start distance.
//
//   Channel   Direction  Handshake                    Payload
//   in_chan   in         valid/ready                  cmd, side, row, col, x, y
//   out_chan  out        valid/ready                  best_row, best_col
//   APB       in/out     psel/penable/pwrite, pready  paddr, pwdata, prdata
//
// A query steps through init, a scan of one stored point per cycle through the
// single read port of the point memory, the drain steps and done, which loads
// the result into the output register; an empty scan goes from init to done.
// A new item is taken while an earlier result still waits on out_chan, but a
// finished query holds its result back until the output register is free.
// The point memory has no reset; loaded entries are the only valid ones.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_grid_point_search (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ngps_in_if.sink                        in_chan,
  ngps_out_if.source                     out_chan,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ngps_pkg::PADDR_W-1:0]   paddr,
  input  logic [ngps_pkg::PDATA_W-1:0]   pwdata,
  output logic [ngps_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import ngps_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  logic [CFG_CNT_W-1:0]  rows_q;
  logic [CFG_CNT_W-1:0]  cols_q;
  logic [CFG_DIST_W-1:0] start_q;
  logic                  cfg_we;

  logic   side_q;
  coord_t qx_q;
  coord_t qy_q;

  row_idx_t r_q;
  col_idx_t c_q;
  row_idx_t r_last;
  col_idx_t c_last;
  logic     at_last;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  coord_t            ram_x;
  coord_t            ram_y;

  logic     v0_q;
  logic     v1_q;
  logic     v2_q;
  row_idx_t r0_q;
  row_idx_t r1_q;
  row_idx_t r2_q;
  col_idx_t c0_q;
  col_idx_t c1_q;
  col_idx_t c2_q;
  coord_t   dx1_q;
  coord_t   dy1_q;
  logic [SQ_W-1:0]  sqx2_q;
  logic [SQ_W-1:0]  sqy2_q;
  logic [SUM_W-1:0] dist_sum;

  dist_t    best_q;
  row_idx_t br_q;
  col_idx_t bc_q;

  logic  out_valid_q;
  logic  out_valid_d;
  grid_t out_row_q;
  grid_t out_col_q;
  logic  out_load;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= ROWS_RESET;
      cols_q  <= COLS_RESET;
      start_q <= START_RESET;
    end else if (cfg_we) begin
      unique case (paddr[PADDR_W-1:2])
        REG_ROWS:  rows_q  <= pwdata[CFG_CNT_W-1:0];
        REG_COLS:  cols_q  <= pwdata[CFG_CNT_W-1:0];
        REG_START: start_q <= pwdata[CFG_DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[PADDR_W-1:2])
      REG_ROWS:  prdata = PDATA_W'(rows_q);
      REG_COLS:  prdata = PDATA_W'(cols_q);
      REG_START: prdata = PDATA_W'(start_q);
      default:   prdata = '0;
    endcase
  end

  // Sequencer.
  ngps_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  assign in_chan.ready = ctrl.in_ready;

  assign r_last = (32'(rows_q) > MAX_ROWS) ? row_idx_t'(MAX_ROWS - 1)
                                           : row_idx_t'(rows_q - 5'd1);
  assign c_last = (32'(cols_q) > MAX_COLS) ? col_idx_t'(MAX_COLS - 1)
                                           : col_idx_t'(cols_q - 5'd1);
  assign at_last = (r_q == r_last) && (c_q == c_last);

  assign out_load = ctrl.emit && (!out_valid_q || out_chan.ready);

  assign status.query_acc = in_chan.valid && ctrl.in_ready && (in_chan.cmd == CMD_QUERY);
  assign status.empty     = (rows_q == '0) || (cols_q == '0);
  assign status.more      = !at_last;
  assign status.out_free  = !out_valid_q || out_chan.ready;

  // Point memory.
  assign ram_we = in_chan.valid && ctrl.in_ready && (in_chan.cmd == CMD_LOAD)
                  && (32'(in_chan.row) < MAX_ROWS) && (32'(in_chan.col) < MAX_COLS);
  assign ram_waddr = {in_chan.camera_side, row_idx_t'(in_chan.row),
                      col_idx_t'(in_chan.col)};
  assign ram_wdata = {coord_t'(in_chan.point_x), coord_t'(in_chan.point_y)};
  assign ram_raddr = {side_q, r_q, c_q};

  ngps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (GRID_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ctrl.issue),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_x    = ram_rdata[ENTRY_W-1:COORD_BITS];
  assign ram_y    = ram_rdata[COORD_BITS-1:0];
  assign dist_sum = SUM_W'(sqx2_q) + SUM_W'(sqy2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v0_q        <= ctrl.issue;
      v1_q        <= v0_q;
      v2_q        <= v1_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (status.query_acc) begin
      side_q <= in_chan.camera_side;
      qx_q   <= coord_t'(in_chan.point_x);
      qy_q   <= coord_t'(in_chan.point_y);
    end

    if (ctrl.init) begin
      r_q <= '0;
      c_q <= '0;
    end else if (ctrl.issue) begin
      if (c_q == c_last) begin
        c_q <= '0;
        r_q <= r_q + row_idx_t'(1);
      end else begin
        c_q <= c_q + col_idx_t'(1);
      end
    end

    r0_q <= r_q;
    c0_q <= c_q;

    r1_q  <= r0_q;
    c1_q  <= c0_q;
    dx1_q <= (qx_q >= ram_x) ? (qx_q - ram_x) : (ram_x - qx_q);
    dy1_q <= (qy_q >= ram_y) ? (qy_q - ram_y) : (ram_y - qy_q);

    r2_q   <= r1_q;
    c2_q   <= c1_q;
    sqx2_q <= SQ_W'(dx1_q) * SQ_W'(dx1_q);
    sqy2_q <= SQ_W'(dy1_q) * SQ_W'(dy1_q);

    if (ctrl.init) begin
      best_q <= DIST_W'(start_q);
      br_q   <= '0;
      bc_q   <= '0;
    end else if (v2_q && (DIST_W'(dist_sum) < best_q)) begin
      best_q <= DIST_W'(dist_sum);
      br_q   <= r2_q;
      bc_q   <= c2_q;
    end

    if (out_load) begin
      out_row_q <= grid_t'(br_q);
      out_col_q <= grid_t'(bc_q);
    end
  end

  assign out_chan.valid    = out_valid_q;
  assign out_chan.best_row = out_row_q;
  assign out_chan.best_col = out_col_q;

  `NGPS_ASSERT_IMPL(a_emit_after_drain, ctrl.emit, !(v0_q || v1_q || v2_q), "result taken before scan drained")
  `NGPS_ASSERT_IMPL(a_no_write_in_scan, ram_we, !ctrl.issue && !v0_q && !v1_q && !v2_q, "point load during a scan")
  `NGPS_ASSERT_IMPL(a_no_accept_in_scan, v2_q, !ctrl.in_ready, "item accepted while a compare is in flight")
  `NGPS_ASSERT_NEXT(a_best_never_rises, v2_q && !ctrl.init, best_q <= $past(best_q), "best distance increased")
endmodule

### hw/rtl/ngps_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ngps_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

### hw/rtl/ngps_seq.sv
// ----------------------------------------------------------------------------
// Grid point search sequencer
// Step counter over the microcode table with conditional jumps.
// ----------------------------------------------------------------------------
module ngps_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ngps_pkg::status_t status_i,
  output ngps_pkg::ctrl_t   ctrl_o
);
  import ngps_pkg::*;

  step_t  step_q;
  step_t  step_d;
  uword_t uw;
  logic   take;

  always_comb begin
    uw = ucode_rom(step_q);
    unique case (uw.cond)
      COND_NEVER:    take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_QUERY:    take = status_i.query_acc;
      COND_EMPTY:    take = status_i.empty;
      COND_MORE:     take = status_i.more;
      COND_OUT_FREE: take = status_i.out_free;
      default:       take = 1'b0;
    endcase
    if (take) begin
      step_d = uw.target;
    end else if (uw.hold) begin
      step_d = step_q;
    end else begin
      step_d = step_q + step_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = uw.act;
endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// Nearest grid point search testbench
// Loads points into both grids, programs scan size and start distance over
// APB, and checks every query result against a nearest-point search kept in
// the bench, under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  import ngps_pkg::*;

  localparam logic SIDE_LEFT   = 1'b0;
  localparam logic SIDE_RIGHT  = 1'b1;
  localparam int   SIDE_BOTH   = 2;
  localparam int   QUIET_LIMIT = 4000;
  localparam int   MAX_REPORTS = 10;
  localparam int   COORD_MAX   = (1 << PT_W) - 1;
  localparam int   START_MAX   = (1 << CFG_DIST_W) - 1;

  typedef struct packed {
    grid_t row;
    grid_t col;
  } grid_pos_t;

  typedef struct packed {
    logic            cmd;
    logic            side;
    grid_t           row;
    grid_t           col;
    logic [PT_W-1:0] x;
    logic [PT_W-1:0] y;
  } grid_item_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  ngps_in_if  in_chan ();
  ngps_out_if out_chan ();

  nearest_grid_point_search dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  coord_t      stored_x [2][MAX_ROWS][MAX_COLS];
  coord_t      stored_y [2][MAX_ROWS][MAX_COLS];
  bit          loaded   [2][MAX_ROWS][MAX_COLS];
  int unsigned rows_in_use;
  int unsigned cols_in_use;
  int unsigned start_distance;
  grid_pos_t   pending_nearest[$];
  int          mismatches;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial out_chan.ready = 1'b0;

  always @(negedge clk_i) begin
    out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic int unsigned scan_rows();
    return (rows_in_use > MAX_ROWS) ? MAX_ROWS : rows_in_use;
  endfunction

  function automatic int unsigned scan_cols();
    return (cols_in_use > MAX_COLS) ? MAX_COLS : cols_in_use;
  endfunction

  function automatic bit region_loaded(logic side);
    for (int r = 0; r < scan_rows(); r++) begin
      for (int c = 0; c < scan_cols(); c++) begin
        if (!loaded[side][r][c]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic grid_pos_t nearest_point(logic side, coord_t qx, coord_t qy);
    longint unsigned best;
    longint unsigned dx;
    longint unsigned dy;
    grid_pos_t       pos;
    best = start_distance;
    pos  = '0;
    for (int r = 0; r < scan_rows(); r++) begin
      for (int c = 0; c < scan_cols(); c++) begin
        dx = (qx > stored_x[side][r][c]) ? qx - stored_x[side][r][c]
                                         : stored_x[side][r][c] - qx;
        dy = (qy > stored_y[side][r][c]) ? qy - stored_y[side][r][c]
                                         : stored_y[side][r][c] - qy;
        if (dx * dx + dy * dy < best) begin
          best    = dx * dx + dy * dy;
          pos.row = grid_t'(r);
          pos.col = grid_t'(c);
        end
      end
    end
    return pos;
  endfunction

  function automatic coord_t near_coord(coord_t base);
    int v;
    v = int'(base) + int'($urandom_range(160)) - 80;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return coord_t'(v);
  endfunction

  function automatic coord_t pick_coord();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic send_item(grid_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_chan.valid       <= 1'b1;
    in_chan.cmd         <= item.cmd;
    in_chan.camera_side <= item.side;
    in_chan.row         <= item.row;
    in_chan.col         <= item.col;
    in_chan.point_x     <= item.x;
    in_chan.point_y     <= item.y;
    @(posedge clk_i);
    while (!in_chan.ready) @(posedge clk_i);
    if (item.cmd == CMD_LOAD) begin
      stored_x[item.side][item.row][item.col] = item.x;
      stored_y[item.side][item.row][item.col] = item.y;
      loaded[item.side][item.row][item.col]   = 1'b1;
    end else begin
      pending_nearest.insert(pending_nearest.size(),
                             nearest_point(item.side, item.x, item.y));
    end
    @(negedge clk_i);
  endtask

  task automatic send_fields(logic cmd, logic side, int row, int col, int x, int y);
    grid_item_t item;
    item.cmd  = cmd;
    item.side = side;
    item.row  = grid_t'(row);
    item.col  = grid_t'(col);
    item.x    = PT_W'(x);
    item.y    = PT_W'(y);
    send_item(item);
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (pending_nearest.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_register(logic [1:0] index, logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(index));
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (index)
      REG_ROWS:  rows_in_use    = value[CFG_CNT_W-1:0];
      REG_COLS:  cols_in_use    = value[CFG_CNT_W-1:0];
      REG_START: start_distance = value[CFG_DIST_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_config(int rows, int cols, int start);
    wait_drained();
    write_register(REG_ROWS, PDATA_W'(rows));
    write_register(REG_COLS, PDATA_W'(cols));
    write_register(REG_START, PDATA_W'(start));
  endtask

  task automatic test_corner_points();
    set_config(2, 2, START_MAX);
    send_fields(CMD_LOAD, SIDE_LEFT, 0, 0, 0, 0);
    send_fields(CMD_LOAD, SIDE_LEFT, 0, 1, COORD_MAX, COORD_MAX);
    send_fields(CMD_LOAD, SIDE_LEFT, 1, 0, COORD_MAX, 0);
    send_fields(CMD_LOAD, SIDE_LEFT, 1, 1, 0, COORD_MAX);
    send_fields(CMD_LOAD, SIDE_RIGHT, 0, 0, 100, 100);
    send_fields(CMD_LOAD, SIDE_RIGHT, 0, 1, 2000, 2000);
    send_fields(CMD_LOAD, SIDE_RIGHT, 1, 0, 2000, 2000);
    send_fields(CMD_LOAD, SIDE_RIGHT, 1, 1, COORD_MAX, COORD_MAX);
    send_fields(CMD_LOAD, SIDE_RIGHT, 15, 15, COORD_MAX, 0);
    send_fields(CMD_QUERY, SIDE_LEFT, 15, 15, COORD_MAX, COORD_MAX);
    send_fields(CMD_QUERY, SIDE_LEFT, 0, 0, 0, COORD_MAX);
    send_fields(CMD_QUERY, SIDE_LEFT, 5, 9, COORD_MAX, 0);
    send_fields(CMD_QUERY, SIDE_RIGHT, 3, 12, 2000, 2000);
    send_fields(CMD_QUERY, SIDE_RIGHT, 0, 0, 0, 0);
  endtask

  task automatic test_start_distance();
    set_config(2, 2, 1);
    send_fields(CMD_QUERY, SIDE_RIGHT, 0, 0, 2001, 2000);
    set_config(2, 2, 2);
    send_fields(CMD_QUERY, SIDE_RIGHT, 0, 0, 2001, 2000);
    set_config(2, 2, 0);
    send_fields(CMD_QUERY, SIDE_LEFT, 0, 0, 0, 0);
  endtask

  task automatic test_empty_scan();
    set_config(0, 2, START_MAX);
    send_fields(CMD_QUERY, SIDE_LEFT, 0, 0, COORD_MAX, COORD_MAX);
    set_config(2, 0, START_MAX);
    send_fields(CMD_QUERY, SIDE_RIGHT, 0, 0, 2000, 2000);
  endtask

  task automatic test_random_mix(int rows, int cols, int start, int side_sel,
                                 int idle_pct, int stall_pct, int queries);
    grid_item_t item;
    int         sent_queries;
    int         r;
    int         c;
    logic       side;
    set_config(rows, cols, start);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent_queries   = 0;
    while (sent_queries < queries) begin
      side      = (side_sel == SIDE_BOTH) ? logic'($urandom_range(1)) : side_sel[0];
      item.side = side;
      item.row  = grid_t'($urandom);
      item.col  = grid_t'($urandom);
      if (region_loaded(side) && $urandom_range(99) < 55) begin
        item.cmd = CMD_QUERY;
        if ($urandom_range(1) == 1 && scan_rows() * scan_cols() != 0) begin
          r      = $urandom_range(scan_rows() - 1);
          c      = $urandom_range(scan_cols() - 1);
          item.x = near_coord(stored_x[side][r][c]);
          item.y = near_coord(stored_y[side][r][c]);
        end else begin
          item.x = PT_W'($urandom);
          item.y = PT_W'($urandom);
        end
        sent_queries++;
      end else begin
        item.cmd = CMD_LOAD;
        if (!region_loaded(side) && $urandom_range(99) < 85) begin
          r = $urandom_range(scan_rows() - 1);
          c = $urandom_range(scan_cols() - 1);
          while (loaded[side][r][c]) begin
            r = $urandom_range(scan_rows() - 1);
            c = $urandom_range(scan_cols() - 1);
          end
          item.row = grid_t'(r);
          item.col = grid_t'(c);
        end
        r = $urandom_range(MAX_ROWS - 1);
        c = $urandom_range(MAX_COLS - 1);
        if ($urandom_range(99) < 20 && loaded[side][r][c]) begin
          // A copy of an existing point makes equal distances, so ties can occur.
          item.x = stored_x[side][r][c];
          item.y = stored_y[side][r][c];
        end else begin
          item.x = pick_coord();
          item.y = pick_coord();
        end
      end
      send_item(item);
    end
  endtask

  always @(posedge clk_i) begin
    grid_pos_t want;
    if (rst_ni && out_chan.valid && out_chan.ready) begin
      if (pending_nearest.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result transfer: row %0d col %0d",
                   out_chan.best_row, out_chan.best_col);
      end else begin
        want = pending_nearest.pop_front();
        if (out_chan.best_row !== want.row || out_chan.best_col !== want.col) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("nearest point mismatch: expected row %0d col %0d, got row %0d col %0d",
                     want.row, want.col, out_chan.best_row, out_chan.best_col);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_chan.valid       = 1'b0;
    in_chan.cmd         = CMD_LOAD;
    in_chan.camera_side = SIDE_LEFT;
    in_chan.row         = '0;
    in_chan.col         = '0;
    in_chan.point_x     = '0;
    in_chan.point_y     = '0;
    rows_in_use         = ROWS_RESET;
    cols_in_use         = COLS_RESET;
    start_distance      = START_RESET;
    mismatches          = 0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    quiet_cycles        = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_corner_points();
    test_start_distance();
    test_empty_scan();
    test_random_mix(2, 3, 10000, SIDE_BOTH, 0, 0, 15);
    test_random_mix(1, 1, 10000, SIDE_BOTH, 55, 55, 8);
    test_random_mix(31, 2, START_MAX, SIDE_BOTH, 55, 0, 15);
    test_random_mix(2, 31, $urandom_range(20000), SIDE_BOTH, 0, 55, 15);
    test_random_mix(4, 4, 10000, SIDE_BOTH, 14, 14, 15);
    test_random_mix(0, 16, START_MAX, SIDE_BOTH, 55, 0, 10);
    test_random_mix(3, 5, 0, SIDE_BOTH, 0, 55, 10);
    test_random_mix(16, 16, 10000, SIDE_RIGHT, 14, 14, 15);
    test_random_mix(17, 20, $urandom_range(START_MAX), SIDE_RIGHT, 0, 0, 10);

    in_chan.valid <= 1'b0;
    while (pending_nearest.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (mismatches == 0 && pending_nearest.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
